[rtl/fdms_pkg.sv]
// ----------------------------------------------------------------------------
// fdms_pkg
// Shared types and constants for the floppy drive mechanism status block.
// ----------------------------------------------------------------------------
package fdms_pkg;

  localparam int MAX_HEAD_POSITION = 255;
  localparam int HEAD_LIMIT_INT    = (MAX_HEAD_POSITION < 255) ? MAX_HEAD_POSITION : 255;
  localparam logic [7:0] HEAD_LIMIT = 8'(HEAD_LIMIT_INT);

  localparam int CFG_DATA_W = 28;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_MOTOR = 3'd1,
    OP_STEP  = 3'd2,
    OP_DISK  = 3'd3,
    OP_HEAD  = 3'd4
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_READY_MODE   = 3'd0,
    REG_SPIN_DOWN    = 3'd1,
    REG_INDEX_PULSE  = 3'd2,
    REG_REVOLUTION   = 3'd3,
    REG_HEAD_COUNT   = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] MODE_SHUGART     = 2'd0;
  localparam logic [1:0] MODE_MOD_SHUGART = 2'd1;
  localparam logic [1:0] MODE_IBM         = 2'd2;

  localparam logic [1:0]  RST_READY_MODE  = MODE_SHUGART;
  localparam logic [27:0] RST_SPIN_DOWN   = 28'd8000000;
  localparam logic [19:0] RST_INDEX_PULSE = 20'd16000;
  localparam logic [27:0] RST_REVOLUTION  = 28'd1600000;
  localparam logic [4:0]  RST_HEAD_COUNT  = 5'd2;

  typedef struct packed {
    logic       ready_line;
    logic       index_line;
    logic       spinning;
    logic       motor_input;
    logic       track_zero;
    logic [7:0] head_position;
    logic [3:0] selected_head;
    logic       step_below_zero;
    logic       disk_in;
  } res_t;

endpackage

[rtl/floppy_drive_mechanism_status.sv]
// ----------------------------------------------------------------------------
// floppy_drive_mechanism_status
// Status side of a floppy drive: motor, rotation, index, ready, head stepping
// and head selection, one command beat in and one status beat out.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   op, motor_request, step_offset,
//                                             disk_insert, head_request
//   out_     output     out_valid / out_ready status lines, head position,
//                                             selected head, step flag
//   cfg_     input      cfg_we                cfg_addr, cfg_wdata
//
// One beat per cycle while in_ready is high; each status is registered.
// Throughput is set by the state update, one 28-bit count and
// compare per beat. A two-entry output (register plus skid) keeps in_ready
// high while one result waits; in_ready drops only when both are full.
// Sync active-low reset clears all but output data, loads register defaults.
// ----------------------------------------------------------------------------
module floppy_drive_mechanism_status
  import fdms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_op,
  input  logic                  in_motor_request,
  input  logic signed [5:0]     in_step_offset,
  input  logic                  in_disk_insert,
  input  logic [3:0]            in_head_request,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ready_line,
  output logic                  out_index_line,
  output logic                  out_spinning,
  output logic                  out_motor_input,
  output logic                  out_track_zero,
  output logic [7:0]            out_head_position,
  output logic [3:0]            out_selected_head,
  output logic                  out_step_below_zero,
  output logic                  out_disk_in
);

  // configuration
  logic [1:0]  ready_mode_r;
  logic [27:0] spin_down_cycles_r;
  logic [19:0] index_pulse_cycles_r;
  logic [27:0] cycles_per_rev_r;
  logic [4:0]  head_count_r;

  // drive state
  logic        motor_latch_r, motor_latch_nxt;
  logic        rotating_r, rotating_nxt;
  logic [27:0] spin_down_left_r, spin_down_left_nxt;
  logic [19:0] pulse_left_r, pulse_left_nxt;
  logic [27:0] ticks_r, ticks_nxt;
  logic [1:0]  index_seen_r, index_seen_nxt;
  logic        ready_flag_r, ready_flag_nxt;
  logic        disk_flag_r, disk_flag_nxt;
  logic [7:0]  position_r, position_nxt;
  logic [3:0]  head_sel_r, head_sel_nxt;
  logic        below;

  // output register and skid
  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r, res;

  logic accept;
  logic [28:0] tick_t;
  logic signed [9:0] new_pos;
  logic [4:0] top_head;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_mode_r         <= RST_READY_MODE;
      spin_down_cycles_r   <= RST_SPIN_DOWN;
      index_pulse_cycles_r <= RST_INDEX_PULSE;
      cycles_per_rev_r     <= RST_REVOLUTION;
      head_count_r         <= RST_HEAD_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_READY_MODE:  ready_mode_r         <= cfg_wdata[1:0];
        REG_SPIN_DOWN:   spin_down_cycles_r   <= cfg_wdata[27:0];
        REG_INDEX_PULSE: index_pulse_cycles_r <= cfg_wdata[19:0];
        REG_REVOLUTION:  cycles_per_rev_r     <= cfg_wdata[27:0];
        REG_HEAD_COUNT:  head_count_r         <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    motor_latch_nxt    = motor_latch_r;
    rotating_nxt       = rotating_r;
    spin_down_left_nxt = spin_down_left_r;
    pulse_left_nxt     = pulse_left_r;
    ticks_nxt          = ticks_r;
    index_seen_nxt     = index_seen_r;
    ready_flag_nxt     = ready_flag_r;
    disk_flag_nxt      = disk_flag_r;
    position_nxt       = position_r;
    head_sel_nxt       = head_sel_r;
    below              = 1'b0;
    tick_t             = {1'b0, ticks_r} + 29'd1;
    new_pos            = $signed({2'b00, position_r}) + 10'(in_step_offset);
    top_head           = (head_count_r != 5'd0) ? head_count_r - 5'd1 : 5'd0;

    unique case (op_t'(in_op))
      OP_TICK: begin
        if (pulse_left_r != 20'd0) pulse_left_nxt = pulse_left_r - 20'd1;
        if (spin_down_left_r > 28'd1) begin
          spin_down_left_nxt = spin_down_left_r - 28'd1;
        end else if (spin_down_left_r == 28'd1) begin
          spin_down_left_nxt = 28'd0;
          rotating_nxt       = !rotating_r;
          if (rotating_r) begin
            if (ready_mode_r == MODE_SHUGART) ready_flag_nxt = 1'b0;
            index_seen_nxt = 2'd0;
          end
        end
        if (rotating_nxt) begin
          if (tick_t >= {1'b0, cycles_per_rev_r}) begin
            if (index_seen_nxt != 2'd3) index_seen_nxt = index_seen_nxt + 2'd1;
            if (index_seen_nxt == 2'd2 &&
                (ready_mode_r == MODE_SHUGART || ready_mode_r == MODE_MOD_SHUGART))
              ready_flag_nxt = 1'b1;
            ticks_nxt      = 28'd0;
            pulse_left_nxt = index_pulse_cycles_r;
          end else begin
            ticks_nxt = tick_t[27:0];
          end
        end
      end
      OP_MOTOR: begin
        if (motor_latch_r != in_motor_request) begin
          motor_latch_nxt = in_motor_request;
          if (rotating_r == in_motor_request) begin
            spin_down_left_nxt = 28'd0;
          end else if (in_motor_request) begin
            rotating_nxt       = 1'b1;
            spin_down_left_nxt = 28'd0;
          end else if (spin_down_left_r == 28'd0) begin
            spin_down_left_nxt = (spin_down_cycles_r != 28'd0) ? spin_down_cycles_r : 28'd1;
          end
        end
      end
      OP_STEP: begin
        if (in_step_offset != 6'sd0) begin
          if (disk_flag_r && ready_mode_r == MODE_IBM) ready_flag_nxt = 1'b1;
          if (new_pos < 10'sd0) begin
            position_nxt = 8'd0;
            below        = 1'b1;
          end else if (new_pos > $signed({2'b00, HEAD_LIMIT})) begin
            position_nxt = HEAD_LIMIT;
          end else begin
            position_nxt = new_pos[7:0];
          end
        end
      end
      OP_DISK: begin
        if (ready_mode_r == MODE_MOD_SHUGART || ready_mode_r == MODE_IBM)
          ready_flag_nxt = 1'b0;
        disk_flag_nxt = in_disk_insert;
      end
      OP_HEAD: begin
        head_sel_nxt = ({1'b0, in_head_request} < top_head) ? in_head_request : top_head[3:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    res.ready_line      = ready_flag_nxt;
    res.index_line      = (pulse_left_nxt != 20'd0);
    res.spinning        = rotating_nxt;
    res.motor_input     = motor_latch_nxt;
    res.track_zero      = (position_nxt == 8'd0);
    res.head_position   = position_nxt;
    res.selected_head   = head_sel_nxt;
    res.step_below_zero = below;
    res.disk_in         = disk_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_latch_r    <= 1'b0;
      rotating_r       <= 1'b0;
      spin_down_left_r <= 28'd0;
      pulse_left_r     <= 20'd0;
      ticks_r          <= 28'd0;
      index_seen_r     <= 2'd0;
      ready_flag_r     <= 1'b0;
      disk_flag_r      <= 1'b0;
      position_r       <= 8'd0;
      head_sel_r       <= 4'd0;
    end else if (accept) begin
      motor_latch_r    <= motor_latch_nxt;
      rotating_r       <= rotating_nxt;
      spin_down_left_r <= spin_down_left_nxt;
      pulse_left_r     <= pulse_left_nxt;
      ticks_r          <= ticks_nxt;
      index_seen_r     <= index_seen_nxt;
      ready_flag_r     <= ready_flag_nxt;
      disk_flag_r      <= disk_flag_nxt;
      position_r       <= position_nxt;
      head_sel_r       <= head_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_valid_r && !out_ready) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end else if (!out_valid_r || out_ready) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ready_line      = out_data_r.ready_line;
  assign out_index_line      = out_data_r.index_line;
  assign out_spinning        = out_data_r.spinning;
  assign out_motor_input     = out_data_r.motor_input;
  assign out_track_zero      = out_data_r.track_zero;
  assign out_head_position   = out_data_r.head_position;
  assign out_selected_head   = out_data_r.selected_head;
  assign out_step_below_zero = out_data_r.step_below_zero;
  assign out_disk_in         = out_data_r.disk_in;

endmodule

[rtl/fdms_checker.sv]
// ----------------------------------------------------------------------------
// fdms_checker
// Port-level checks for the floppy drive mechanism status block.
// ----------------------------------------------------------------------------
module fdms_checker
  import fdms_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_track_zero,
  input logic [7:0] out_head_position,
  input logic       out_step_below_zero
);

  // back-pressure only with a result pending
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  a_track_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_track_zero == (out_head_position == 8'd0)))
    else $error("track zero disagrees with head position");

  a_below_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_step_below_zero) |-> (out_head_position == 8'd0))
    else $error("clamped step not at position zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_head_position)))
    else $error("stalled result beat changed");

endmodule

bind floppy_drive_mechanism_status fdms_checker u_fdms_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_track_zero      (out_track_zero),
  .out_head_position   (out_head_position),
  .out_step_below_zero (out_step_below_zero)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the floppy drive mechanism status block: a short
// directed walk over the extremes and corner rules, then random command
// streams under several register settings, with idle bursts on both sides,
// one long receiver hold-off and a drain pause. Every status beat is checked
// field by field against an in-bench model of the drive or a typed value.
// ----------------------------------------------------------------------------
module tb;
  import fdms_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       motor;
    logic [5:0] step;
    logic       disk;
    logic [3:0] head;
  } cmd_t;

  typedef struct {
    bit          wr;
    cmd_t        cmd;
    cfg_reg_t    addr;
    logic [27:0] val;
    bit          typed;
    res_t        want;
  } plan_row_t;

  typedef struct {
    logic [1:0]  mode;
    logic [27:0] spin;
    logic [19:0] pulse;
    logic [27:0] rev;
    logic [4:0]  heads;
    int          stall;
    int          gap;
    bit          climb;
    int          items;
  } phase_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            in_op;
  logic                  in_motor_request;
  logic signed [5:0]     in_step_offset;
  logic                  in_disk_insert;
  logic [3:0]            in_head_request;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_ready_line;
  logic                  out_index_line;
  logic                  out_spinning;
  logic                  out_motor_input;
  logic                  out_track_zero;
  logic [7:0]            out_head_position;
  logic [3:0]            out_selected_head;
  logic                  out_step_below_zero;
  logic                  out_disk_in;

  floppy_drive_mechanism_status u_top (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // drive model: register copies and mechanism state
  logic [1:0]  reg_mode;
  logic [27:0] reg_spin_down;
  logic [19:0] reg_pulse_len;
  logic [27:0] reg_rev_len;
  logic [4:0]  reg_heads;
  logic        motor_on;
  logic        rotating;
  logic [27:0] spin_left;
  logic [19:0] pulse_left;
  logic [27:0] rev_ticks;
  logic [1:0]  holes_seen;
  logic        ready_q;
  logic        disk_q;
  logic [7:0]  head_pos;
  logic [3:0]  head_q;

  res_t status_due[$];
  int   errors;
  int   cmds;
  int   beats;
  int   writes;
  int   holes;
  int   clamps;
  int   stall_pct;
  int   gap_pct;
  bit   long_hold;

  plan_row_t plan [26];
  phase_t    phases [7];

  function automatic void set_spin(logic on);
    rotating = on;
    if (!on) begin
      if (reg_mode == MODE_SHUGART) ready_q = 1'b0;
      holes_seen = 2'd0;
    end
  endfunction

  function automatic res_t predict_status(cmd_t c);
    res_t        r;
    logic        below;
    logic [28:0] t;
    logic [4:0]  top;
    int          off;
    int          np;
    below = 1'b0;
    case (c.op)
      OP_TICK: begin
        if (pulse_left != 20'd0) pulse_left = pulse_left - 20'd1;
        if (spin_left != 28'd0) begin
          if (spin_left > 28'd1) spin_left = spin_left - 28'd1;
          else begin
            spin_left = 28'd0;
            set_spin(!rotating);
          end
        end
        if (rotating) begin
          t = {1'b0, rev_ticks} + 29'd1;
          if (t >= {1'b0, reg_rev_len}) begin
            if (holes_seen != 2'd3) holes_seen = holes_seen + 2'd1;
            if (holes_seen == 2'd2 &&
                (reg_mode == MODE_SHUGART || reg_mode == MODE_MOD_SHUGART))
              ready_q = 1'b1;
            rev_ticks = 28'd0;
            pulse_left = reg_pulse_len;
            holes++;
          end else begin
            rev_ticks = t[27:0];
          end
        end
      end
      OP_MOTOR: begin
        if (motor_on != c.motor) begin
          motor_on = c.motor;
          if (rotating == c.motor) spin_left = 28'd0;
          else if (c.motor) begin
            set_spin(1'b1);
            spin_left = 28'd0;
          end else if (spin_left == 28'd0) begin
            spin_left = (reg_spin_down != 28'd0) ? reg_spin_down : 28'd1;
          end
        end
      end
      OP_STEP: begin
        off = int'($signed(c.step));
        if (off != 0) begin
          if (disk_q && reg_mode == MODE_IBM) ready_q = 1'b1;
          np = int'(head_pos) + off;
          if (np < 0) begin
            np = 0;
            below = 1'b1;
            clamps++;
          end else if (np > int'(HEAD_LIMIT)) begin
            np = int'(HEAD_LIMIT);
          end
          head_pos = 8'(np);
        end
      end
      OP_DISK: begin
        if (reg_mode == MODE_MOD_SHUGART || reg_mode == MODE_IBM) ready_q = 1'b0;
        disk_q = c.disk;
      end
      OP_HEAD: begin
        top = (reg_heads != 5'd0) ? reg_heads - 5'd1 : 5'd0;
        head_q = ({1'b0, c.head} < top) ? c.head : top[3:0];
      end
      default: ;
    endcase
    r.ready_line      = ready_q;
    r.index_line      = (pulse_left != 20'd0);
    r.spinning        = rotating;
    r.motor_input     = motor_on;
    r.track_zero      = (head_pos == 8'd0);
    r.head_position   = head_pos;
    r.selected_head   = head_q;
    r.step_below_zero = below;
    r.disk_in         = disk_q;
    return r;
  endfunction

  task automatic send_cmd(cmd_t c, bit typed, res_t want);
    res_t got;
    in_valid         <= 1'b1;
    in_op            <= c.op;
    in_motor_request <= c.motor;
    in_step_offset   <= c.step;
    in_disk_insert   <= c.disk;
    in_head_request  <= c.head;
    do @(posedge clk); while (!in_ready);
    got = predict_status(c);
    status_due.insert(status_due.size(), typed ? want : got);
    cmds++;
  endtask

  task automatic take_gap();
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t a, logic [27:0] v);
    if (in_valid) in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (a)
      REG_READY_MODE:  reg_mode = v[1:0];
      REG_SPIN_DOWN:   reg_spin_down = v;
      REG_INDEX_PULSE: reg_pulse_len = v[19:0];
      REG_REVOLUTION:  reg_rev_len = v;
      REG_HEAD_COUNT:  reg_heads = v[4:0];
      default: ;
    endcase
    writes++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : status_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: status beat with nothing expected, expected none, got %h", $time,
                 {out_ready_line, out_index_line, out_spinning, out_motor_input,
                  out_track_zero, out_head_position, out_selected_head,
                  out_step_below_zero, out_disk_in});
      end else begin
        want = status_due.pop_front();
        check_field("ready_line", 8'(want.ready_line), 8'(out_ready_line));
        check_field("index_line", 8'(want.index_line), 8'(out_index_line));
        check_field("spinning", 8'(want.spinning), 8'(out_spinning));
        check_field("motor_input", 8'(want.motor_input), 8'(out_motor_input));
        check_field("track_zero", 8'(want.track_zero), 8'(out_track_zero));
        check_field("head_position", want.head_position, out_head_position);
        check_field("selected_head", 8'(want.selected_head), 8'(out_selected_head));
        check_field("step_below_zero", 8'(want.step_below_zero), 8'(out_step_below_zero));
        check_field("disk_in", 8'(want.disk_in), 8'(out_disk_in));
        beats++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    cmd_t c;
    int   pick;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_op            = OP_TICK;
    in_motor_request = 1'b0;
    in_step_offset   = '0;
    in_disk_insert   = 1'b0;
    in_head_request  = '0;
    errors = 0;
    cmds = 0;
    beats = 0;
    writes = 0;
    holes = 0;
    clamps = 0;
    stall_pct = 15;
    gap_pct = 15;
    long_hold = 1'b0;

    reg_mode      = RST_READY_MODE;
    reg_spin_down = RST_SPIN_DOWN;
    reg_pulse_len = RST_INDEX_PULSE;
    reg_rev_len   = RST_REVOLUTION;
    reg_heads     = RST_HEAD_COUNT;
    motor_on   = 1'b0;
    rotating   = 1'b0;
    spin_left  = '0;
    pulse_left = '0;
    rev_ticks  = '0;
    holes_seen = '0;
    ready_q    = 1'b0;
    disk_q     = 1'b0;
    head_pos   = '0;
    head_q     = '0;

    // directed walk; typed status only where it follows at a glance
    plan = '{
      '{1'b0, '{OP_TICK, 1'b0, 6'd0, 1'b0, 4'd0}, REG_READY_MODE, 28'd0,
        1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 4'd0, 1'b0, 1'b0}},
      // most negative step from track zero
      '{1'b0, '{OP_STEP, 1'b0, 6'h20, 1'b0, 4'd0}, REG_READY_MODE, 28'd0,
        1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 4'd0, 1'b1, 1'b0}},
      '{1'b0, '{OP_STEP, 1'b0, 6'd31, 1'b0, 4'd0}, REG_READY_MODE, 28'd0,
        1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd31, 4'd0, 1'b0, 1'b0}},
      '{1'b0, '{OP_STEP, 1'b1, 6'd0, 1'b1, 4'hF}, REG_READY_MODE, 28'd0, 1'b0, '0},
      // head request above the head count is clamped
      '{1'b0, '{OP_HEAD, 1'b0, 6'd0, 1'b0, 4'hF}, REG_READY_MODE, 28'd0,
        1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd31, 4'd1, 1'b0, 1'b0}},
      '{1'b0, '{OP_UNUSED_LO, 1'b1, 6'h3F, 1'b1, 4'hF}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_UNUSED_HI, 1'b1, 6'h3F, 1'b1, 4'hF}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_DISK, 1'b0, 6'd0, 1'b1, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_MOTOR, 1'b1, 6'd0, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b1, '0, REG_REVOLUTION, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_TICK, 1'b0, 6'd0, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_TICK, 1'b0, 6'd0, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b1, '0, REG_SPIN_DOWN, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_MOTOR, 1'b0, 6'd0, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_TICK, 1'b0, 6'd0, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b1, '0, REG_HEAD_COUNT, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_HEAD, 1'b0, 6'd0, 1'b0, 4'hF}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b1, '0, REG_READY_MODE, 28'(MODE_IBM), 1'b0, '0},
      '{1'b0, '{OP_STEP, 1'b0, 6'd1, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_DISK, 1'b0, 6'd0, 1'b1, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b1, '0, REG_INDEX_PULSE, 28'hFFFFF, 1'b0, '0},
      '{1'b1, '0, REG_READY_MODE, 28'(MODE_NONE), 1'b0, '0},
      '{1'b0, '{OP_MOTOR, 1'b1, 6'd0, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_TICK, 1'b0, 6'd0, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_DISK, 1'b0, 6'd0, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0},
      '{1'b0, '{OP_STEP, 1'b0, 6'h1F, 1'b0, 4'd0}, REG_READY_MODE, 28'd0, 1'b0, '0}
    };

    phases = '{
      '{MODE_SHUGART, 28'd5, 20'd3, 28'd8, 5'd2, 20, 20, 1'b0, 110},
      '{MODE_MOD_SHUGART, 28'd1, 20'd1, 28'd1, 5'd16, 0, 0, 1'b0, 90},
      '{MODE_IBM, 28'hFFFFFFF, 20'hFFFFF, 28'hFFFFFFF, 5'd31, 30, 30, 1'b1, 100},
      '{MODE_NONE, 28'd0, 20'd0, 28'd0, 5'd0, 15, 10, 1'b0, 100},
      '{MODE_SHUGART, 28'd20, 20'd6, 28'd13, 5'd1, 10, 40, 1'b0, 100},
      '{MODE_SHUGART, 28'd1, 20'd1, 28'd1, 5'd1, 25, 25, 1'b0, 100},
      '{MODE_MOD_SHUGART, 28'd3, 20'd2, 28'd4, 5'd4, 0, 0, 1'b0, 120}
    };
    phases[5].mode  = 2'($urandom_range(0, 3));
    phases[5].spin  = 28'($urandom_range(1, 40));
    phases[5].pulse = 20'($urandom_range(0, 15));
    phases[5].rev   = 28'($urandom_range(0, 20));
    phases[5].heads = 5'($urandom_range(0, 31));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].wr) write_reg(plan[i].addr, plan[i].val);
      else begin
        send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
        take_gap();
      end
    end

    foreach (phases[p]) begin
      write_reg(REG_READY_MODE, 28'(phases[p].mode));
      write_reg(REG_SPIN_DOWN, phases[p].spin);
      write_reg(REG_INDEX_PULSE, 28'(phases[p].pulse));
      write_reg(REG_REVOLUTION, phases[p].rev);
      write_reg(REG_HEAD_COUNT, 28'(phases[p].heads));
      stall_pct = phases[p].stall;
      gap_pct   = phases[p].gap;
      for (int k = 0; k < phases[p].items; k++) begin
        c = cmd_t'(15'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 8) c.op = OP_MOTOR;
        else if (pick < 18) begin
          c.op = OP_STEP;
          if (phases[p].climb) c.step = 6'($urandom_range(1, 31));
        end
        else if (pick < 22) c.op = OP_DISK;
        else if (pick < 26) c.op = OP_HEAD;
        else if (pick >= 30) c.op = OP_TICK;
        send_cmd(c, 1'b0, '0);
        take_gap();
      end

      // back-pressure: hold the receiver while commands keep coming, then drain
      if (p == 1) begin
        long_hold = 1'b1;
        repeat (24) send_cmd(cmd_t'(15'($urandom)), 1'b0, '0);
        in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
      end
    end

    if (in_valid) in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d commands and %0d status beats across %0d register writes",
             cmds, beats, writes);
    $display("model saw %0d index holes and %0d steps clamped at track zero", holes, clamps);
    if (errors == 0 && status_due.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
rtl/fdms_pkg.sv
rtl/floppy_drive_mechanism_status.sv
rtl/fdms_checker.sv
tb/tb.sv
